[rtl/gb5_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the 5x5 Gaussian blur core.
// Used by every module of the block; depends on nothing else.
package gb5_pkg;

    localparam int PIX_W      = 8;
    localparam int KSIZE      = 5;
    localparam int LINES      = KSIZE - 1;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int WEIGHT_W   = 8;
    localparam int MIN_DIM    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Four stored rows packed into one memory word, oldest row in the low byte.
    localparam int LINE_W     = LINES * PIX_W;
    localparam int COLUMN_W   = KSIZE * PIX_W;

    // A class sum adds at most eight pixels.
    localparam int CSUM_W     = PIX_W + 3;
    localparam int PROD_W     = CSUM_W + WEIGHT_W;
    localparam int ACC_W      = 21;
    localparam int SCALE_W    = ACC_W + 8;
    localparam int SHIFT      = 16;
    localparam int QUOT_W     = SCALE_W - SHIFT;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH       = 3'd0,
        CFG_IMAGE_HEIGHT      = 3'd1,
        CFG_WEIGHT_CORNER     = 3'd2,
        CFG_WEIGHT_OUTER_NEAR = 3'd3,
        CFG_WEIGHT_OUTER_MID  = 3'd4,
        CFG_WEIGHT_INNER_DIAG = 3'd5,
        CFG_WEIGHT_INNER_EDGE = 3'd6,
        CFG_WEIGHT_CENTER     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
    } t_ctl;

    typedef struct packed {
        logic [WEIGHT_W-1:0] corner;
        logic [WEIGHT_W-1:0] outer_near;
        logic [WEIGHT_W-1:0] outer_mid;
        logic [WEIGHT_W-1:0] inner_diag;
        logic [WEIGHT_W-1:0] inner_edge;
        logic [WEIGHT_W-1:0] center;
    } t_weights;

    typedef struct packed {
        logic [CSUM_W-1:0] corner;
        logic [CSUM_W-1:0] outer_near;
        logic [CSUM_W-1:0] outer_mid;
        logic [CSUM_W-1:0] inner_diag;
        logic [CSUM_W-1:0] inner_edge;
        logic [CSUM_W-1:0] center;
    } t_class_sums;

endpackage

[rtl/gb5_line_mem.sv]
`timescale 1ns / 1ps
// Line store: one synchronous memory word per image column holding four rows.
// Depends on gb5_pkg for the word width.
module gb5_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [gb5_pkg::LINE_W-1:0] o_rd_data,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [gb5_pkg::LINE_W-1:0] i_wr_data
);

    logic [gb5_pkg::LINE_W-1:0] r_mem [DEPTH];
    logic [gb5_pkg::LINE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // The read register holds while the pipeline is stalled.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/gb5_window.sv]
`timescale 1ns / 1ps
// 5x5 pixel window and the per-weight-class pixel sums taken from it.
// Depends on gb5_pkg for widths and the class sum struct.
module gb5_window (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_shift,
    input  logic [gb5_pkg::COLUMN_W-1:0] i_column,
    output gb5_pkg::t_class_sums         o_sums
);

    localparam int K = gb5_pkg::KSIZE;
    localparam int W = gb5_pkg::CSUM_W;

    logic [gb5_pkg::PIX_W-1:0] r_win [K][K];
    gb5_pkg::t_class_sums       r_sums;
    gb5_pkg::t_class_sums       n_sums;

    // Shift every row left by one and insert the new column on the right;
    // column entry 0 is the oldest row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < K; r++) begin
                for (int c = 0; c < K; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_en && i_shift) begin
            for (int r = 0; r < K; r++) begin
                for (int c = 0; c < K - 1; c++) begin
                    r_win[r][c] <= r_win[r][c+1];
                end
                r_win[r][K-1] <= i_column[r*gb5_pkg::PIX_W +: gb5_pkg::PIX_W];
            end
        end
    end

    always_comb begin
        n_sums.corner     = W'(r_win[0][0]) + W'(r_win[0][4])
                          + W'(r_win[4][0]) + W'(r_win[4][4]);
        n_sums.outer_near = W'(r_win[0][1]) + W'(r_win[0][3])
                          + W'(r_win[4][1]) + W'(r_win[4][3])
                          + W'(r_win[1][0]) + W'(r_win[3][0])
                          + W'(r_win[1][4]) + W'(r_win[3][4]);
        n_sums.outer_mid  = W'(r_win[0][2]) + W'(r_win[4][2])
                          + W'(r_win[2][0]) + W'(r_win[2][4]);
        n_sums.inner_diag = W'(r_win[1][1]) + W'(r_win[1][3])
                          + W'(r_win[3][1]) + W'(r_win[3][3]);
        n_sums.inner_edge = W'(r_win[1][2]) + W'(r_win[3][2])
                          + W'(r_win[2][1]) + W'(r_win[2][3]);
        n_sums.center     = W'(r_win[2][2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sums <= n_sums;
        end
    end

    assign o_sums = r_sums;

endmodule

[rtl/gb5_mac.sv]
`timescale 1ns / 1ps
// Weighting of the class sums, final accumulate, scaling by 240/65536 and
// saturation. Depends on gb5_pkg for widths and structs.
module gb5_mac (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  gb5_pkg::t_class_sums           i_sums,
    input  gb5_pkg::t_weights              i_weights,
    output logic [gb5_pkg::PIX_W-1:0]      o_blurred
);

    localparam int P = gb5_pkg::PROD_W;
    localparam int A = gb5_pkg::ACC_W;
    localparam int S = gb5_pkg::SCALE_W;

    logic [P-1:0] r_prod [6];
    logic [A-1:0] acc;
    logic [S-1:0] scaled;
    logic [gb5_pkg::QUOT_W-1:0] quot;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod[0] <= P'(i_sums.corner)     * P'(i_weights.corner);
            r_prod[1] <= P'(i_sums.outer_near) * P'(i_weights.outer_near);
            r_prod[2] <= P'(i_sums.outer_mid)  * P'(i_weights.outer_mid);
            r_prod[3] <= P'(i_sums.inner_diag) * P'(i_weights.inner_diag);
            r_prod[4] <= P'(i_sums.inner_edge) * P'(i_weights.inner_edge);
            r_prod[5] <= P'(i_sums.center)     * P'(i_weights.center);
        end
    end

    // Times 240 is times 256 less times 16.
    always_comb begin
        acc = A'(r_prod[0]) + A'(r_prod[1]) + A'(r_prod[2])
            + A'(r_prod[3]) + A'(r_prod[4]) + A'(r_prod[5]);
        scaled = (S'(acc) << 8) - (S'(acc) << 4);
        quot = scaled[S-1:gb5_pkg::SHIFT];
        o_blurred = (|quot[gb5_pkg::QUOT_W-1:gb5_pkg::PIX_W]) ? '1
                                                              : quot[gb5_pkg::PIX_W-1:0];
    end

endmodule

[rtl/gaussian_blur_5x5_core.sv]
`timescale 1ns / 1ps
// Streaming 5x5 Gaussian blur core; uses gb5_pkg, gb5_line_mem, gb5_window, gb5_mac.
// Throughput: one pixel word per cycle while the output is not stalled. Each accepted
// word uses the line memory's single read port, and its write-back uses the single
// write port while the word is held in stage 1.
// Reset (synchronous, active low) clears counters, pipeline and window and
// loads the default registers; the line memory is not cleared and needs no pass.
module gaussian_blur_5x5_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Pixel input channel.
    input  logic                             i_pix_valid,
    input  logic [gb5_pkg::PIX_W-1:0]        i_pixel,
    output logic                             o_pix_stall,
    // Result output channel.
    output logic                             o_out_valid,
    output logic [gb5_pkg::PIX_W-1:0]        o_blurred,
    output logic                             o_last_of_frame,
    input  logic                             i_out_stall,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gb5_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gb5_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    // Compare width wide enough for both the width register and MAX_WIDTH.
    localparam int WCW = ($clog2(MAX_WIDTH + 1) > gb5_pkg::WIDTH_W)
                         ? $clog2(MAX_WIDTH + 1) : gb5_pkg::WIDTH_W;
    localparam logic [WCW-1:0] MAXW = WCW'(MAX_WIDTH);
    localparam logic [WCW-1:0] MINW = WCW'(gb5_pkg::MIN_DIM);
    localparam logic [gb5_pkg::HEIGHT_W-1:0] MINH = gb5_pkg::HEIGHT_W'(gb5_pkg::MIN_DIM);

    // Configuration registers. The port is always ready; writes must arrive only while
    // the block is idle, and the block itself does not enforce this.
    logic [gb5_pkg::WIDTH_W-1:0]  r_image_width;
    logic [gb5_pkg::HEIGHT_W-1:0] r_image_height;
    gb5_pkg::t_weights            r_weights;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width        <= gb5_pkg::WIDTH_W'(640);
            r_image_height       <= gb5_pkg::HEIGHT_W'(480);
            r_weights.corner     <= gb5_pkg::WEIGHT_W'(1);
            r_weights.outer_near <= gb5_pkg::WEIGHT_W'(4);
            r_weights.outer_mid  <= gb5_pkg::WEIGHT_W'(7);
            r_weights.inner_diag <= gb5_pkg::WEIGHT_W'(16);
            r_weights.inner_edge <= gb5_pkg::WEIGHT_W'(26);
            r_weights.center     <= gb5_pkg::WEIGHT_W'(41);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (gb5_pkg::t_cfg_idx'(i_cfg_index))
                gb5_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[gb5_pkg::WIDTH_W-1:0];
                end
                gb5_pkg::CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[gb5_pkg::HEIGHT_W-1:0];
                end
                gb5_pkg::CFG_WEIGHT_CORNER: begin
                    r_weights.corner <= i_cfg_data[gb5_pkg::WEIGHT_W-1:0];
                end
                gb5_pkg::CFG_WEIGHT_OUTER_NEAR: begin
                    r_weights.outer_near <= i_cfg_data[gb5_pkg::WEIGHT_W-1:0];
                end
                gb5_pkg::CFG_WEIGHT_OUTER_MID: begin
                    r_weights.outer_mid <= i_cfg_data[gb5_pkg::WEIGHT_W-1:0];
                end
                gb5_pkg::CFG_WEIGHT_INNER_DIAG: begin
                    r_weights.inner_diag <= i_cfg_data[gb5_pkg::WEIGHT_W-1:0];
                end
                gb5_pkg::CFG_WEIGHT_INNER_EDGE: begin
                    r_weights.inner_edge <= i_cfg_data[gb5_pkg::WEIGHT_W-1:0];
                end
                gb5_pkg::CFG_WEIGHT_CENTER: begin
                    r_weights.center <= i_cfg_data[gb5_pkg::WEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline moves as one whenever the output register is free or
    // being drained. A stalled output therefore holds every stage, including
    // the line memory read register.
    logic advance;
    logic accept;

    assign advance     = !(o_out_valid && i_out_stall);
    assign o_pix_stall = !advance;
    assign accept      = i_pix_valid && advance;

    // Effective image size: widths are clamped into [5, MAX_WIDTH], heights
    // are raised to at least 5.
    logic [WCW-1:0]              w_raw;
    logic [WCW-1:0]              w_eff;
    logic [WCW-1:0]              w_last;
    logic [gb5_pkg::HEIGHT_W-1:0] h_eff;
    logic [gb5_pkg::HEIGHT_W-1:0] h_last;

    always_comb begin
        w_raw  = WCW'(r_image_width);
        if (w_raw < MINW) begin
            w_eff = MINW;
        end else if (w_raw > MAXW) begin
            w_eff = MAXW;
        end else begin
            w_eff = w_raw;
        end
        w_last = w_eff - WCW'(1);
        h_eff  = (r_image_height < MINH) ? MINH : r_image_height;
        h_last = h_eff - gb5_pkg::HEIGHT_W'(1);
    end

    // Raster position of the next pixel word.
    logic [gb5_pkg::COL_W-1:0] r_col;
    logic [gb5_pkg::COL_W-1:0] n_col;
    logic [gb5_pkg::ROW_W-1:0] r_row;
    logic [gb5_pkg::ROW_W-1:0] n_row;
    logic                      col_end;
    logic                      row_end;
    logic                      emit;
    logic                      last;

    always_comb begin
        col_end = WCW'(r_col) >= w_last;
        row_end = r_row >= h_last;
        emit    = (r_col >= gb5_pkg::COL_W'(gb5_pkg::LINES))
               && (r_row >= gb5_pkg::ROW_W'(gb5_pkg::LINES));
        last    = col_end && row_end;
        n_col   = r_col;
        n_row   = r_row;
        if (accept) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + gb5_pkg::ROW_W'(1);
            end else begin
                n_col = r_col + gb5_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage 1: the line memory word for this column is being read; the pixel
    // and its column address wait alongside it. The column counter never
    // exceeds the clamped width, so it always fits the memory address.
    gb5_pkg::t_ctl             r_s1;
    logic [gb5_pkg::PIX_W-1:0] r_s1_pixel;
    logic [AW-1:0]             r_s1_addr;
    logic [AW-1:0]             rd_addr;
    logic [gb5_pkg::LINE_W-1:0] rd_data;
    logic [gb5_pkg::LINE_W-1:0] wr_data;
    logic [gb5_pkg::COLUMN_W-1:0] new_column;

    assign rd_addr = AW'(r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (advance) begin
            r_s1.valid <= accept;
            r_s1.emit  <= emit;
            r_s1.last  <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_pixel <= i_pixel;
            r_s1_addr  <= rd_addr;
        end
    end

    // The same column is touched again only a full row later (at least five
    // words), so the write-back of one word never races the read of the next.
    gb5_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (advance),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (advance && r_s1.valid),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (wr_data)
    );

    // Every stored row moves up by one: the oldest drops out and the new pixel
    // becomes the newest stored row. The window column is the four stored rows
    // plus the incoming pixel at the bottom.
    assign new_column = {r_s1_pixel, rd_data};
    assign wr_data    = new_column[gb5_pkg::COLUMN_W-1:gb5_pkg::PIX_W];

    // Stage 2: window updated; stage 3: class sums registered; stage 4:
    // products registered; then the output register.
    gb5_pkg::t_ctl        r_s2;
    gb5_pkg::t_ctl        r_s3;
    gb5_pkg::t_ctl        r_s4;
    gb5_pkg::t_class_sums sums;
    logic [gb5_pkg::PIX_W-1:0] blurred;

    gb5_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_shift  (r_s1.valid),
        .i_column (new_column),
        .o_sums   (sums)
    );

    gb5_mac u_mac (
        .i_clk     (i_clk),
        .i_en      (advance),
        .i_sums    (sums),
        .i_weights (r_weights),
        .o_blurred (blurred)
    );

    logic                      r_out_valid;
    logic [gb5_pkg::PIX_W-1:0] r_blurred;
    logic                      r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2        <= '0;
            r_s3        <= '0;
            r_s4        <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s2        <= r_s1;
            r_s3        <= r_s2;
            r_s4        <= r_s3;
            // Border positions travel through the pipeline but make no result.
            r_out_valid <= r_s4.valid && r_s4.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_blurred <= blurred;
            r_last    <= r_s4.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_blurred       = r_blurred;
    assign o_last_of_frame = r_last;

endmodule

[rtl/gb5_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the Gaussian blur core, attached by the bind below.
// Depends on gb5_pkg for port widths and on gaussian_blur_5x5_core.
module gb5_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_pix_stall,
    input logic                           o_out_valid,
    input logic [gb5_pkg::PIX_W-1:0]      o_blurred,
    input logic                           o_last_of_frame,
    input logic                           i_out_stall
);

    // A held result blocks new pixels, so no word can be lost behind it.
    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_pix_stall)
        else $error("pixel input not stalled while result is held");

    // Nothing is offered on the first cycle out of reset.
    a_reset_clears_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result withdrawn while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_blurred) && $stable(o_last_of_frame)))
        else $error("result word changed while stalled");

endmodule

bind gaussian_blur_5x5_core gb5_checker u_gb5_checker (.*);
